// ===== hdl/plc_pkg.sv =====
// plc_pkg: shared types and codes for the positional list store
// operation and status codes, and the control word broadcast to every cell
// no dependencies
package plc_pkg;

  // wide enough for any position, count or cell index up to 1024 entries
  localparam int POS_BITS = 11;

  localparam logic [2:0] OP_APPEND      = 3'd0;
  localparam logic [2:0] OP_INSERT_AT   = 3'd1;
  localparam logic [2:0] OP_REMOVE_LAST = 3'd2;
  localparam logic [2:0] OP_REMOVE_AT   = 3'd3;
  localparam logic [2:0] OP_READ_AT     = 3'd4;
  localparam logic [2:0] OP_FIRST       = 3'd5;
  localparam logic [2:0] OP_LAST        = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NULL  = 2'd3;

  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [POS_BITS-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== hdl/plc_if.sv =====
// plc_in_if, plc_out_if: valid/ready channels of the positional list store
// command channel carries the operation, response channel the result
// no dependencies
interface plc_in_if #(
  parameter int ELEMENT_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              opcode;
  logic [7:0]              position;
  logic [ELEMENT_BITS-1:0] element;

  modport source (output valid, opcode, position, element, input ready);
  modport sink (input valid, opcode, position, element, output ready);
endinterface

interface plc_out_if #(
  parameter int ELEMENT_BITS = 32,
  parameter int COUNT_BITS   = 5
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [ELEMENT_BITS-1:0] element_out;
  logic [COUNT_BITS-1:0]   count;

  modport source (output valid, status, element_out, count, input ready);
  modport sink (input valid, status, element_out, count, output ready);
endinterface

// ===== hdl/plc_cell.sv =====
// plc_cell: one list slot of the positional list store
// loads a new word, takes its left or right neighbor, and drives a read tap
// depends on plc_pkg
module plc_cell #(
  parameter int IDX          = 0,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                    clk,
  input  plc_pkg::cell_ctrl_t     ctrl,
  input  logic [ELEMENT_BITS-1:0] elem_in,
  input  logic [ELEMENT_BITS-1:0] left,
  input  logic [ELEMENT_BITS-1:0] right,
  output logic [ELEMENT_BITS-1:0] val,
  output logic [ELEMENT_BITS-1:0] tap
);

  localparam logic [plc_pkg::POS_BITS-1:0] MY_IDX = plc_pkg::POS_BITS'(IDX);

  logic hit;
  logic above;

  assign hit   = (ctrl.pos == MY_IDX);
  assign above = (ctrl.pos < MY_IDX);
  assign tap   = hit ? val : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins && hit) begin
      val <= elem_in;
    end else if (ctrl.ins && above) begin
      val <= left;
    end else if (ctrl.rem && (hit || above)) begin
      val <= right;
    end
  end

endmodule

// ===== hdl/positional_list_store.sv =====
// positional_list_store: ordered list of up to CAPACITY words in a row of cells
// channel  dir  payload                        transfer when
// cmd      in   opcode, position, element      cmd.valid && cmd.ready
// rsp      out  status, element_out, count     rsp.valid && rsp.ready
// one operation per cycle unless the response stalls; the cells from the position up shift at once on insert or remove
// the result is registered and the next command is taken while it is taken
// rst (synchronous) empties the list; cell contents stay undefined
// a stalled response holds cmd.ready low until it is taken
// depends on plc_pkg, plc_if, plc_cell
module positional_list_store #(
  parameter int CAPACITY     = 16,
  parameter int ELEMENT_BITS = 32
) (
  input logic     clk,
  input logic     rst,
  plc_in_if.sink  cmd,
  plc_out_if.source rsp
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int PW   = plc_pkg::POS_BITS;

  logic [CNTW-1:0]         entry_count;
  logic [CNTW-1:0]         count_next;
  logic                    accept;
  logic [PW-1:0]           cnt_ext;
  logic [PW-1:0]           pos_ext;
  logic [PW-1:0]           last_pos;
  logic [1:0]              status_next;
  logic                    rd_used;
  logic [ELEMENT_BITS-1:0] rd_data;
  plc_pkg::cell_ctrl_t     ctrl;

  logic [ELEMENT_BITS-1:0] vals [CAPACITY];
  logic [ELEMENT_BITS-1:0] taps [CAPACITY];
  logic [ELEMENT_BITS-1:0] lefts [CAPACITY];
  logic [ELEMENT_BITS-1:0] rights [CAPACITY];

  assign cmd.ready = !rsp.valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign cnt_ext   = PW'(entry_count);
  assign pos_ext   = PW'(cmd.position);
  assign last_pos  = cnt_ext - PW'(1);

  always_comb begin
    status_next = plc_pkg::ST_EMPTY;
    count_next  = entry_count;
    rd_used     = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    ctrl.pos    = '0;
    case (cmd.opcode)
      plc_pkg::OP_APPEND, plc_pkg::OP_INSERT_AT: begin
        if (cmd.element == '0) begin
          status_next = plc_pkg::ST_NULL;
        end else if (entry_count == CNTW'(CAPACITY)) begin
          status_next = plc_pkg::ST_FULL;
        end else begin
          status_next = plc_pkg::ST_OK;
          count_next  = entry_count + CNTW'(1);
          ctrl.ins    = accept;
          ctrl.pos    = (cmd.opcode == plc_pkg::OP_APPEND || pos_ext > cnt_ext) ?
                        cnt_ext : pos_ext;
        end
      end
      plc_pkg::OP_REMOVE_LAST, plc_pkg::OP_REMOVE_AT: begin
        if (entry_count != '0) begin
          status_next = plc_pkg::ST_OK;
          count_next  = entry_count - CNTW'(1);
          rd_used     = 1'b1;
          ctrl.rem    = accept;
          ctrl.pos    = (cmd.opcode == plc_pkg::OP_REMOVE_LAST || pos_ext >= cnt_ext) ?
                        last_pos : pos_ext;
        end
      end
      plc_pkg::OP_READ_AT: begin
        ctrl.pos = pos_ext;
        if (pos_ext < cnt_ext) begin
          status_next = plc_pkg::ST_OK;
          rd_used     = 1'b1;
        end
      end
      plc_pkg::OP_FIRST: begin
        if (entry_count != '0) begin
          status_next = plc_pkg::ST_OK;
          rd_used     = 1'b1;
        end
      end
      plc_pkg::OP_LAST: begin
        ctrl.pos = last_pos;
        if (entry_count != '0) begin
          status_next = plc_pkg::ST_OK;
          rd_used     = 1'b1;
        end
      end
      default: begin
        status_next = plc_pkg::ST_EMPTY;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign lefts[g] = '0;
      end else begin : g_inner_l
        assign lefts[g] = vals[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign rights[g] = '0;
      end else begin : g_inner_r
        assign rights[g] = vals[g+1];
      end
      plc_cell #(
        .IDX          (g),
        .ELEMENT_BITS (ELEMENT_BITS)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .elem_in (cmd.element),
        .left    (lefts[g]),
        .right   (rights[g]),
        .val     (vals[g]),
        .tap     (taps[g])
      );
    end
  endgenerate

  // at most one tap is nonzero
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= count_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.element_out <= rd_used ? rd_data : '0;
      rsp.count       <= count_next;
    end
  end

endmodule

// ===== sim/tb_positional_list_store.sv =====
// tb_positional_list_store: self-checking regression of the positional list store
// directed and random operations with random gaps on both channels, checked by a predictor
// depends on plc_pkg, plc_if and positional_list_store
`timescale 1ns / 100ps

module tb_positional_list_store;

  localparam int CAPACITY     = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int COUNT_BITS   = 5;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [1:0]              status;
    logic [ELEMENT_BITS-1:0] element_out;
    logic [COUNT_BITS-1:0]   count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  plc_in_if #(.ELEMENT_BITS(ELEMENT_BITS)) cmd_if ();
  plc_out_if #(.ELEMENT_BITS(ELEMENT_BITS), .COUNT_BITS(COUNT_BITS)) rsp_if ();

  positional_list_store #(
    .CAPACITY    (CAPACITY),
    .ELEMENT_BITS(ELEMENT_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  always #4 clk = ~clk;

  logic [ELEMENT_BITS-1:0] list_cells [CAPACITY];
  int                      list_held = 0;
  list_result_t            pending_results [$];
  list_result_t            want;
  int                      errors = 0;
  bit                      no_idle = 1'b0;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic list_result_t predict_result(input logic [2:0] op,
                                                  input logic [7:0] pos,
                                                  input logic [ELEMENT_BITS-1:0] elem);
    list_result_t r;
    int           at;
    int           i;
    r.status      = plc_pkg::ST_OK;
    r.element_out = '0;
    case (op)
      plc_pkg::OP_APPEND, plc_pkg::OP_INSERT_AT: begin
        at = (op == plc_pkg::OP_APPEND || int'(pos) > list_held) ? list_held : int'(pos);
        if (elem == '0) begin
          r.status = plc_pkg::ST_NULL;
        end else if (list_held >= CAPACITY) begin
          r.status = plc_pkg::ST_FULL;
        end else begin
          for (i = list_held; i > at; i--) list_cells[i] = list_cells[i-1];
          list_cells[at] = elem;
          list_held++;
        end
      end
      plc_pkg::OP_REMOVE_LAST, plc_pkg::OP_REMOVE_AT: begin
        if (list_held == 0) begin
          r.status = plc_pkg::ST_EMPTY;
        end else begin
          at = (op == plc_pkg::OP_REMOVE_LAST || int'(pos) >= list_held) ?
               list_held - 1 : int'(pos);
          r.element_out = list_cells[at];
          for (i = at; i + 1 < list_held; i++) list_cells[i] = list_cells[i+1];
          list_held--;
        end
      end
      plc_pkg::OP_READ_AT, plc_pkg::OP_FIRST, plc_pkg::OP_LAST: begin
        at = (op == plc_pkg::OP_READ_AT) ? int'(pos) :
             (op == plc_pkg::OP_FIRST) ? 0 : list_held - 1;
        if (list_held == 0 || at >= list_held) r.status = plc_pkg::ST_EMPTY;
        else r.element_out = list_cells[at];
      end
      default: r.status = plc_pkg::ST_EMPTY;
    endcase
    r.count = list_held[COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic issue_op(input logic [2:0] op, input logic [7:0] pos,
                          input logic [ELEMENT_BITS-1:0] elem);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.opcode   <= op;
    cmd_if.position <= pos;
    cmd_if.element  <= elem;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    pending_results.push_back(predict_result(op, pos, elem));
  endtask

  task automatic issue_random(input int grow_pct, input int shrink_pct);
    logic [2:0]              op;
    logic [7:0]              pos;
    logic [ELEMENT_BITS-1:0] elem;
    int                      r;
    r = $urandom_range(99);
    if (r < grow_pct) begin
      op = $urandom_range(1) ? plc_pkg::OP_APPEND : plc_pkg::OP_INSERT_AT;
    end else if (r < grow_pct + shrink_pct) begin
      op = $urandom_range(1) ? plc_pkg::OP_REMOVE_LAST : plc_pkg::OP_REMOVE_AT;
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: op = plc_pkg::OP_READ_AT;
        4, 5:       op = plc_pkg::OP_FIRST;
        6, 7, 8:    op = plc_pkg::OP_LAST;
        default:    op = OP_UNUSED;
      endcase
    end
    if ($urandom_range(99) < 70) pos = 8'($urandom_range(list_held));
    else pos = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 5) elem = '0;
    else if (r < 10) elem = '1;
    else elem = $urandom;
    issue_op(op, pos, elem);
  endtask

  task automatic test_empty_list();
    issue_op(plc_pkg::OP_FIRST, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_LAST, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_READ_AT, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_REMOVE_LAST, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_REMOVE_AT, 8'hFF, 32'h0);
    issue_op(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    issue_op(plc_pkg::OP_APPEND, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_INSERT_AT, 8'h00, 32'h0);
  endtask

  task automatic test_insert_positions();
    issue_op(plc_pkg::OP_INSERT_AT, 8'hFF, 32'hFFFF_FFFF);
    issue_op(plc_pkg::OP_INSERT_AT, 8'h00, 32'h0000_0001);
    issue_op(plc_pkg::OP_APPEND, 8'hFF, 32'h8000_0000);
    issue_op(plc_pkg::OP_INSERT_AT, 8'h01, 32'h5A5A_A5A5);
    issue_op(plc_pkg::OP_READ_AT, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_READ_AT, 8'h03, 32'h0);
    issue_op(plc_pkg::OP_READ_AT, 8'h04, 32'h0);
    issue_op(plc_pkg::OP_READ_AT, 8'hFF, 32'h0);
    issue_op(plc_pkg::OP_FIRST, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_LAST, 8'h00, 32'h0);
  endtask

  task automatic test_remove_positions();
    issue_op(plc_pkg::OP_REMOVE_AT, 8'hFF, 32'h0);
    issue_op(plc_pkg::OP_REMOVE_AT, 8'h01, 32'h0);
    issue_op(plc_pkg::OP_REMOVE_AT, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_REMOVE_LAST, 8'h00, 32'h0);
    issue_op(plc_pkg::OP_REMOVE_LAST, 8'h00, 32'h0);
  endtask

  task automatic test_random_mix(input int items);
    repeat (items) issue_random(35, 35);
  endtask

  task automatic test_full_list(input int items);
    repeat (items) issue_random(75, 10);
  endtask

  task automatic test_drain_to_empty(input int items);
    repeat (items) issue_random(10, 75);
  endtask

  task automatic test_back_to_back(input int items);
    no_idle = 1'b1;
    repeat (items) issue_random(40, 35);
    no_idle = 1'b0;
  endtask

  // response side stalls
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer pending: status %0d element_out %h count %0d",
               rsp_if.status, rsp_if.element_out, rsp_if.count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.element_out !== want.element_out) begin
          $error("element_out: expected %h actual %h", want.element_out, rsp_if.element_out);
          errors++;
        end
        if (rsp_if.count !== want.count) begin
          $error("count: expected %0d actual %0d", want.count, rsp_if.count);
          errors++;
        end
      end
    end
  end

  initial begin
    cmd_if.valid    = 1'b0;
    cmd_if.opcode   = plc_pkg::OP_APPEND;
    cmd_if.position = '0;
    cmd_if.element  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_insert_positions();
    test_remove_positions();
    test_random_mix(450);
    test_full_list(200);
    test_drain_to_empty(150);
    test_back_to_back(350);
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("positional_list_store regression: pass");
    end else begin
      $display("positional_list_store regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("positional_list_store regression: fail");
    $finish;
  end

endmodule
